// ===== rtl/core/dws_pkg.sv =====
package dws_pkg;

   localparam int WORDS        = 16;
   localparam int MAX_WORD_LEN = 16;

   localparam int WORD_W = $clog2(WORDS);
   localparam int POS_W  = $clog2(MAX_WORD_LEN);
   localparam int CNT_W  = $clog2(WORDS + 1);
   localparam int LEN_W  = 5;
   localparam int BYTE_W = 8;

   localparam logic [1:0] REQ_CHAR = 2'd0;
   localparam logic [1:0] REQ_LEN  = 2'd1;
   localparam logic [1:0] REQ_TEXT = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef logic [MAX_WORD_LEN-1:0][BYTE_W-1:0] row_type;

   typedef struct packed {
      logic              char_en;
      logic              len_en;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] value;
      logic [LEN_W-1:0]  len;
   } dict_wr_type;

   typedef struct packed {
      row_type          row;
      logic [LEN_W-1:0] len;
   } dict_rd_type;

endpackage

// ===== rtl/core/dws_dict.sv =====
module dws_dict (
   input  logic                       clock,
   input  logic                       reset,
   input  dws_pkg::dict_wr_type       wr,
   input  logic                       rd_en,
   input  logic [dws_pkg::WORD_W-1:0] rd_addr,
   output dws_pkg::dict_rd_type       rd
);

   // One row per word, so that a whole word is read in one access.
   dws_pkg::row_type char_mem [dws_pkg::WORDS];
   logic [dws_pkg::LEN_W-1:0] len_ff [dws_pkg::WORDS];
   dws_pkg::row_type rd_row_ff;
   logic [dws_pkg::LEN_W-1:0] rd_len_ff;

   always_ff @(posedge clock) begin
      if (wr.char_en) begin
         char_mem[wr.word][wr.pos] <= wr.value;
      end
      if (rd_en) begin
         rd_row_ff <= char_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dws_pkg::WORDS; i++) begin
            len_ff[i] <= '0;
         end
      end else if (wr.len_en) begin
         len_ff[wr.word] <= wr.len;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_len_ff <= len_ff[rd_addr];
      end
   end

   assign rd.row = rd_row_ff;
   assign rd.len = rd_len_ff;

endmodule

// ===== rtl/core/dws_match.sv =====
module dws_match (
   input  dws_pkg::dict_rd_type                cand,
   input  dws_pkg::row_type                    recent,
   input  logic [dws_pkg::MAX_WORD_LEN-1:0]    hist,
   output logic                                hit
);

   logic [dws_pkg::LEN_W-1:0] lm1;
   logic                      len_ok;

   // The word's last character lines up with the newest byte.
   always_comb begin
      lm1    = cand.len - dws_pkg::LEN_W'(1);
      len_ok = (cand.len != '0) &&
               (cand.len <= dws_pkg::LEN_W'(dws_pkg::MAX_WORD_LEN));
      hit    = len_ok && hist[lm1[dws_pkg::POS_W-1:0]];
      for (int k = 0; k < dws_pkg::MAX_WORD_LEN; k++) begin
         if (dws_pkg::LEN_W'(k) < cand.len) begin
            if (cand.row[dws_pkg::POS_W'(lm1 - dws_pkg::LEN_W'(k))] != recent[k]) begin
               hit = 1'b0;
            end
         end
      end
   end

endmodule

// ===== rtl/core/dictionary_word_segmentation_top.sv =====
// Dictionary word segmentation. Load transactions (req_type 0 stores one
// dictionary character, req_type 1 stores a word length, 0 meaning unused)
// are answered in the cycle after acceptance with breakable and is_final at 0,
// as is the unused code 3. A text byte (req_type 2) starts a scan of the
// sixteen dictionary slots, one slot per cycle through a single shared
// compare unit fed by the registered read port of the dictionary memory;
// the result is registered once the last slot has been compared, and the
// block accepts nothing while a scan is running, so the scan of a text
// byte ends before the next transaction is taken. A byte marked
// first_of_text clears the byte and reachability history so that only the
// start of the text is reachable.
module dictionary_word_segmentation_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [3:0] req_word_index,
   input  logic [3:0] req_char_pos,
   input  logic [7:0] req_char_value,
   input  logic [4:0] req_word_len,
   input  logic       req_first_of_text,
   input  logic       req_last_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_breakable,
   output logic       rsp_is_final
);

   dws_pkg::state_type state_ff, state_in;

   logic [dws_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             cmp_valid_ff, cmp_valid_in;
   logic                             reach_ff, reach_in;
   logic                             last_ff, last_in;
   dws_pkg::row_type                 recent_ff, recent_in;
   logic [dws_pkg::MAX_WORD_LEN-1:0] hist_ff, hist_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_brk_ff, rsp_brk_in;
   logic                             rsp_fin_ff, rsp_fin_in;

   logic                 accept;
   logic                 is_text;
   logic                 scan_done;
   logic                 rd_en;
   logic                 hit;
   dws_pkg::dict_wr_type wr;
   dws_pkg::dict_rd_type cand;

   assign accept    = req_valid && req_ready;
   assign is_text   = (req_type == dws_pkg::REQ_TEXT);
   // The last slot's compare happens once the counter has passed every slot.
   assign scan_done = (state_ff == dws_pkg::ST_SCAN) && cmp_valid_ff &&
                      (cnt_ff == dws_pkg::CNT_W'(dws_pkg::WORDS));

   // Dictionary writes happen only on accepted load transactions; slots or
   // positions beyond the configured sizes are ignored.
   always_comb begin
      wr.char_en = accept && (req_type == dws_pkg::REQ_CHAR) &&
                   (int'(req_word_index) < dws_pkg::WORDS) &&
                   (int'(req_char_pos) < dws_pkg::MAX_WORD_LEN);
      wr.len_en  = accept && (req_type == dws_pkg::REQ_LEN) &&
                   (int'(req_word_index) < dws_pkg::WORDS);
      wr.word    = dws_pkg::WORD_W'(req_word_index);
      wr.pos     = dws_pkg::POS_W'(req_char_pos);
      wr.value   = req_char_value;
      wr.len     = req_word_len;
   end

   dws_dict u_dict (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (dws_pkg::WORD_W'(cnt_ff)),
      .rd      (cand)
   );

   dws_match u_match (
      .cand   (cand),
      .recent (recent_ff),
      .hist   (hist_ff),
      .hit    (hit)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dws_pkg::ST_IDLE: begin
            if (accept && is_text) begin
               state_in = dws_pkg::ST_SCAN;
            end
         end
         dws_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = dws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dws_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer. A new transaction is taken only when the
   // result register is free or is being emptied in the same cycle.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         dws_pkg::ST_IDLE: begin
            req_ready = !reset && (!rsp_valid_ff || rsp_ready);
         end
         dws_pkg::ST_SCAN: begin
            rd_en = (cnt_ff < dws_pkg::CNT_W'(dws_pkg::WORDS));
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cnt_in       = cnt_ff;
      cmp_valid_in = rd_en;
      reach_in     = reach_ff;
      last_in      = last_ff;
      recent_in    = recent_ff;
      hist_in      = hist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_brk_in   = rsp_brk_ff;
      rsp_fin_in   = rsp_fin_ff;

      if (rd_en) begin
         cnt_in = cnt_ff + dws_pkg::CNT_W'(1);
      end
      if (cmp_valid_ff && hit) begin
         reach_in = 1'b1;
      end

      if (accept) begin
         if (is_text) begin
            // The newest byte enters the history before the scan; the
            // reachability history is shifted only when the scan ends.
            cnt_in   = '0;
            reach_in = 1'b0;
            last_in  = req_last_of_text;
            if (req_first_of_text) begin
               recent_in = '0;
               hist_in   = dws_pkg::MAX_WORD_LEN'(1);
            end else begin
               recent_in = {recent_ff[dws_pkg::MAX_WORD_LEN-2:0], 8'h00};
            end
            recent_in[0] = req_char_value;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_brk_in   = 1'b0;
            rsp_fin_in   = 1'b0;
         end
      end

      if (scan_done) begin
         hist_in      = {hist_ff[dws_pkg::MAX_WORD_LEN-2:0], reach_in};
         rsp_valid_in = 1'b1;
         rsp_brk_in   = reach_in;
         rsp_fin_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dws_pkg::ST_IDLE;
         cnt_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         reach_ff     <= 1'b0;
         recent_ff    <= '0;
         hist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmp_valid_ff <= cmp_valid_in;
         reach_ff     <= reach_in;
         recent_ff    <= recent_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      rsp_brk_ff <= rsp_brk_in;
      rsp_fin_ff <= rsp_fin_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_breakable = rsp_brk_ff;
   assign rsp_is_final  = rsp_fin_ff;

endmodule

// ===== rtl/core/dws_checker.sv =====
module dws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_breakable,
   input logic       rsp_is_final
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_breakable) &&
                                  $stable(rsp_is_final))
      else $error("stalled result changed");

   // A load or unused request is answered in the next cycle with zeros.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type != dws_pkg::REQ_TEXT) |=>
         rsp_valid && !rsp_breakable && !rsp_is_final)
      else $error("load transaction not answered with zeros");

   // A text byte keeps the block busy while it scans the dictionary.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == dws_pkg::REQ_TEXT) |=> !req_ready)
      else $error("ready during scan");

   // No new transaction while a result is waiting and not taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("ready with blocked result");

endmodule

bind dictionary_word_segmentation_top dws_checker u_dws_checker (.*);

// ===== dv/dictionary_word_segmentation_top_tb.sv =====
module dictionary_word_segmentation_top_tb;

   // The package names the three load and text codes; the spare code is
   // named here so that it is never written as a bare literal.
   localparam logic [1:0] REQ_NOP = 2'd3;

   // The limit lies far above what a correct run needs, since each text
   // byte holds the block only for one dictionary scan plus the random gaps,
   // so that it only catches a block that has hung.
   localparam int CYCLE_LIMIT    = 800000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 330;
   localparam int PRESSURE_PHASE = 4;
   localparam int NUM_PHASES     = 5;

   // Idle and stall percentages per phase: none, sender only, receiver
   // only, both, and finally the back-pressure phase with a long hold.
   localparam int SEND_IDLE [NUM_PHASES] = '{0, 59, 0, 29, 0};
   localparam int RSP_STALL [NUM_PHASES] = '{0, 0, 59, 29, 0};

   typedef struct packed {
      logic [1:0]                 kind;
      logic [3:0]                 word;
      logic [3:0]                 pos;
      logic [dws_pkg::BYTE_W-1:0] value;
      logic [dws_pkg::LEN_W-1:0]  len;
      logic                       first;
      logic                       last;
   } seg_req_type;

   typedef struct packed {
      logic breakable;
      logic is_final;
   } verdict_type;

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic [1:0] req_type          = REQ_NOP;
   logic [3:0] req_word_index    = '0;
   logic [3:0] req_char_pos      = '0;
   logic [7:0] req_char_value    = '0;
   logic [4:0] req_word_len      = '0;
   logic       req_first_of_text = 1'b0;
   logic       req_last_of_text  = 1'b0;
   logic       rsp_ready         = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_breakable;
   logic       rsp_is_final;

   dictionary_word_segmentation_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_word_index    (req_word_index),
      .req_char_pos      (req_char_pos),
      .req_char_value    (req_char_value),
      .req_word_len      (req_word_len),
      .req_first_of_text (req_first_of_text),
      .req_last_of_text  (req_last_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_breakable     (rsp_breakable),
      .rsp_is_final      (rsp_is_final)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Transactions waiting to be offered, and the verdicts predicted for
   // transactions that the block has accepted but not yet answered.
   seg_req_type pending_reqs [$];
   verdict_type verdict_queue [$];

   int issued_count  = 0;
   int checked_count = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   bit hold_request  = 1'b0;
   bit hold_served   = 1'b0;

   // The predictor's own copy of the block's state. The newest text byte
   // sits in entry 0 of the byte history, and bit k of the reach history
   // says whether the text could be split k bytes back from its end.
   logic [dws_pkg::BYTE_W-1:0] pred_chars [dws_pkg::WORDS][dws_pkg::MAX_WORD_LEN] =
      '{default: '0};
   logic [dws_pkg::LEN_W-1:0]  pred_lens [dws_pkg::WORDS] = '{default: '0};
   dws_pkg::row_type           pred_recent = '0;
   logic [dws_pkg::MAX_WORD_LEN-1:0] pred_reach = '0;

   // A separate picture of the dictionary for building stimulus. It runs
   // ahead of the predictor, since whole phases are queued at once, and it
   // records which characters have been written so that no text ever makes
   // the block compare a character that was never loaded.
   logic [dws_pkg::BYTE_W-1:0] gen_chars [dws_pkg::WORDS][dws_pkg::MAX_WORD_LEN] =
      '{default: '0};
   logic [dws_pkg::LEN_W-1:0]  gen_lens [dws_pkg::WORDS] = '{default: '0};
   bit gen_written [dws_pkg::WORDS][dws_pkg::MAX_WORD_LEN] = '{default: 1'b0};
   logic [dws_pkg::BYTE_W-1:0] alphabet [4] = '{8'h61, 8'h62, 8'h63, 8'h64};

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Works out the verdict for one accepted transaction and moves the
   // predicted state on. A text byte is breakable when some used word of a
   // legal length ends at it and begins at a position that was reachable.
   function automatic verdict_type predict_segmentation(input seg_req_type r);
      verdict_type v;
      logic        hit;
      logic        ok;
      int          len;
      v   = '0;
      hit = 1'b0;
      case (r.kind)
         dws_pkg::REQ_CHAR: pred_chars[r.word][r.pos] = r.value;
         dws_pkg::REQ_LEN:  pred_lens[r.word] = r.len;
         dws_pkg::REQ_TEXT: begin
            if (r.first) begin
               pred_recent = '0;
               pred_reach  = '0;
               pred_reach[0] = 1'b1;
            end
            pred_recent = {pred_recent[dws_pkg::MAX_WORD_LEN-2:0], r.value};
            for (int w = 0; w < dws_pkg::WORDS; w++) begin
               len = int'(pred_lens[w]);
               ok  = 1'b0;
               if (len != 0 && len <= dws_pkg::MAX_WORD_LEN) begin
                  ok = pred_reach[len-1];
                  for (int k = 0; k < len; k++) begin
                     if (pred_chars[w][len-1-k] != pred_recent[k]) ok = 1'b0;
                  end
               end
               if (ok) hit = 1'b1;
            end
            pred_reach  = {pred_reach[dws_pkg::MAX_WORD_LEN-2:0], hit};
            v.breakable = hit;
            v.is_final  = r.last;
         end
         default: ;
      endcase
      return v;
   endfunction

   // Sender. A new transaction is put up only when the channel is free or
   // the current one is being taken at this edge, so that the payload holds
   // steady while valid waits for ready.
   always @(posedge clock) begin : req_driver
      seg_req_type offered;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            verdict_queue.push_back(predict_segmentation(offered));
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_reqs.pop_front();
               req_valid         <= 1'b1;
               req_type          <= offered.kind;
               req_word_index    <= offered.word;
               req_char_pos      <= offered.pos;
               req_char_value    <= offered.value;
               req_word_len      <= offered.len;
               req_first_of_text <= offered.first;
               req_last_of_text  <= offered.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Every result transaction is checked against the oldest
   // verdict still waiting; ready stalls at random and is held low for the
   // whole of the long hold-off.
   always @(posedge clock) begin : rsp_monitor
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_breakable !== want.breakable) begin
                  report_mismatch($sformatf("breakable is %b, expected %b",
                                            rsp_breakable, want.breakable));
               end
               if (rsp_is_final !== want.is_final) begin
                  report_mismatch($sformatf("is_final is %b, expected %b",
                                            rsp_is_final, want.is_final));
               end
               checked_count++;
            end
         end
         rsp_ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // The long hold-off counts its own cycles once the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_request && !hold_served) begin
         rsp_hold_left <= LONG_HOLD;
         hold_served   <= 1'b1;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] kind, input int word, input int pos,
                           input int value, input int len, input bit first,
                           input bit last);
      seg_req_type r;
      r.kind  = kind;
      r.word  = word[3:0];
      r.pos   = pos[3:0];
      r.value = value[7:0];
      r.len   = len[4:0];
      r.first = first;
      r.last  = last;
      pending_reqs.push_back(r);
      issued_count++;
      if (kind == dws_pkg::REQ_CHAR) begin
         gen_chars[r.word][r.pos]   = r.value;
         gen_written[r.word][r.pos] = 1'b1;
      end else if (kind == dws_pkg::REQ_LEN) begin
         gen_lens[r.word] = r.len;
      end
   endtask

   // Loads a whole word: every character that the length will make the
   // block compare is written before the length itself.
   task automatic load_word(input int slot, input int len);
      for (int p = 0; p < len && p < dws_pkg::MAX_WORD_LEN; p++) begin
         push_req(dws_pkg::REQ_CHAR, slot, p, alphabet[$urandom_range(3)],
                  $urandom_range(31), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      push_req(dws_pkg::REQ_LEN, slot, $urandom_range(15), $urandom_range(255), len,
               1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // Builds a text mostly out of words now in the dictionary, with the odd
   // stray byte, so that splits succeed often and fail now and then. Without
   // a start mark the bytes carry on from whatever text came before.
   task automatic send_text(input int tokens, input bit marked);
      logic [7:0] text_bytes [$];
      int         used [$];
      int         s;
      for (int w = 0; w < dws_pkg::WORDS; w++) begin
         if (gen_lens[w] != 0 && gen_lens[w] <= dws_pkg::MAX_WORD_LEN) used.push_back(w);
      end
      for (int t = 0; t < tokens; t++) begin
         if (used.size() != 0 && $urandom_range(99) < 85) begin
            s = used[$urandom_range(used.size() - 1)];
            for (int p = 0; p < gen_lens[s]; p++) text_bytes.push_back(gen_chars[s][p]);
         end else if ($urandom_range(99) < 80) begin
            text_bytes.push_back(alphabet[$urandom_range(3)]);
         end else begin
            text_bytes.push_back(8'($urandom_range(255)));
         end
      end
      foreach (text_bytes[i]) begin
         push_req(dws_pkg::REQ_TEXT, $urandom_range(15), $urandom_range(15), text_bytes[i],
                  $urandom_range(31), marked && (i == 0), i == text_bytes.size() - 1);
      end
   endtask

   task automatic wait_for_results();
      while (checked_count != issued_count) @(negedge clock);
   endtask

   initial begin : stimulus
      int goal;
      int slot;
      int len;
      int prefix;
      int r;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The spare code with every field at its top value must change
      // nothing, and a byte with no start mark after reset finds no
      // reachable position.
      push_req(REQ_NOP, 15, 15, 8'hFF, 31, 1'b1, 1'b1);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'h5A, 0, 1'b0, 1'b1);
      // Two short words at the extremes of the byte range, a character at
      // the last slot and position, and two lengths beyond the word limit
      // whose characters are never compared.
      push_req(dws_pkg::REQ_CHAR, 0, 0, 8'hFF, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_CHAR, 0, 1, 8'h00, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_LEN, 0, 0, 0, 2, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_CHAR, 15, 0, 8'hFF, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_CHAR, 15, 15, 8'h80, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_LEN, 15, 0, 0, 1, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_LEN, 3, 0, 0, 31, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_LEN, 4, 0, 0, dws_pkg::MAX_WORD_LEN + 1, 1'b0, 1'b0);
      // A text that splits at every byte, then bytes after the end mark,
      // which extend the same text until a split is no longer possible.
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'hFF, 0, 1'b1, 1'b0);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'h00, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'hFF, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'h00, 0, 1'b0, 1'b1);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'hFF, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'h01, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'h00, 0, 1'b0, 1'b0);
      // A one-byte text marked both first and last, then a slot released by
      // a zero length so that its word no longer matches.
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'h00, 0, 1'b1, 1'b1);
      push_req(dws_pkg::REQ_LEN, 15, 0, 0, 0, 1'b0, 1'b0);
      push_req(dws_pkg::REQ_TEXT, 0, 0, 8'hFF, 0, 1'b1, 1'b1);
      wait_for_results();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         rsp_stall_pct = RSP_STALL[phase];
         goal = issued_count + PHASE_ITEMS;
         while (issued_count < goal) begin
            r = $urandom_range(99);
            if (r < 10) begin
               // Reload a few slots, sometimes over a fresh alphabet. Most
               // words are short; a few use the full length, a few are
               // released and a few are given a length too long to match.
               if ($urandom_range(1)) begin
                  foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(255));
               end
               repeat ($urandom_range(1, 4)) begin
                  slot = $urandom_range(dws_pkg::WORDS - 1);
                  r    = $urandom_range(99);
                  if (r < 60)      len = $urandom_range(1, 3);
                  else if (r < 75) len = $urandom_range(4, 8);
                  else if (r < 85) len = $urandom_range(9, dws_pkg::MAX_WORD_LEN);
                  else if (r < 90) len = dws_pkg::MAX_WORD_LEN;
                  else if (r < 95) len = 0;
                  else             len = $urandom_range(dws_pkg::MAX_WORD_LEN + 1, 31);
                  load_word(slot, len);
               end
            end else if (r < 78) begin
               send_text($urandom_range(1, 6), $urandom_range(9) != 0);
            end else begin
               case ($urandom_range(3))
                  0: push_req(REQ_NOP, $urandom_range(15), $urandom_range(15),
                              $urandom_range(255), $urandom_range(31),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                  1: push_req(dws_pkg::REQ_TEXT, $urandom_range(15), $urandom_range(15),
                              $urandom_range(255), $urandom_range(31), 1'b0,
                              1'($urandom_range(1)));
                  2: push_req(dws_pkg::REQ_CHAR, $urandom_range(15), $urandom_range(15),
                              $urandom_range(255), $urandom_range(31),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                  default: begin
                     // A lone length write may only cover characters that
                     // have already been written in that slot.
                     slot   = $urandom_range(dws_pkg::WORDS - 1);
                     prefix = 0;
                     while (prefix < dws_pkg::MAX_WORD_LEN && gen_written[slot][prefix])
                        prefix++;
                     case ($urandom_range(2))
                        0:       len = 0;
                        1:       len = $urandom_range(0, prefix);
                        default: len = $urandom_range(dws_pkg::MAX_WORD_LEN + 1, 31);
                     endcase
                     push_req(dws_pkg::REQ_LEN, slot, $urandom_range(15),
                              $urandom_range(255), len,
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                  end
               endcase
            end
         end
         // The long hold-off starts with a full queue of transactions behind
         // it, so the block fills and has to stall its input.
         if (phase == PRESSURE_PHASE) hold_request = 1'b1;
         // The sender pauses at the end of every phase until each
         // outstanding transaction has been answered.
         wait_for_results();
      end

      repeat (dws_pkg::WORDS + 8) @(negedge clock);
      if (verdict_queue.size() != 0) begin
         report_mismatch($sformatf("%0d verdicts never answered", verdict_queue.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
